// ----- hw/rtl/binary_gcd_lcm_unit_core_defines.svh -----
// assertion macros shared by the gcd/lcm unit rtl
// no dependencies; included by binary_gcd_lcm_unit_core only
`ifndef BINARY_GCD_LCM_UNIT_CORE_DEFINES_SVH
`define BINARY_GCD_LCM_UNIT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BGL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BGL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bgl_pkg.sv -----
// shared constants and types for the binary gcd/lcm unit
// no dependencies
package bgl_pkg;

    localparam int WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STRIP,
        ST_REDUCE,
        ST_SCALE,
        ST_DIVIDE,
        ST_MULT,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/bgl_in_if.sv -----
// operand channel of the binary gcd/lcm unit: valid/ready plus two operands
// depends on bgl_pkg
interface bgl_in_if #(
    parameter int WIDTH = bgl_pkg::WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] x_value;
    logic [WIDTH-1:0] y_value;

    modport source (output valid, output x_value, output y_value, input ready);
    modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

// ----- hw/rtl/bgl_out_if.sv -----
// result channel of the binary gcd/lcm unit: valid/ready plus gcd, lcm, overflow
// depends on bgl_pkg
interface bgl_out_if #(
    parameter int WIDTH = bgl_pkg::WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] gcd_result;
    logic [WIDTH-1:0] lcm_result;
    logic             lcm_overflow;

    modport source (output valid, output gcd_result, output lcm_result,
                    output lcm_overflow, input ready);
    modport sink   (input valid, input gcd_result, input lcm_result,
                    input lcm_overflow, output ready);
endinterface

// ----- hw/rtl/binary_gcd_lcm_unit_core.sv -----
// Binary (Stein) gcd and lcm of two unsigned WIDTH-bit operands. One item is
// taken at a time: i_in.ready is high only while the unit is idle, and the
// result sits in an output register, so a new item can be accepted while the
// previous result waits. The reduce loop's subtracts, the divide and the
// multiply share one WIDTH+2 bit add/subtract unit under a small sequencer:
// common factors of two are stripped one per cycle, then each cycle either
// halves y, swaps x and y, or subtracts, the gcd is rescaled, y is divided
// by the gcd with a restoring divider, and x times the quotient is formed
// by shift-and-add. An item with a zero operand skips the loops and goes
// from the check straight to the result; otherwise the time an item takes
// is set by the data-dependent reduce loop. lcm_result keeps the low WIDTH
// bits and lcm_overflow flags a product that does not fit.
// depends on bgl_pkg, bgl_in_if, bgl_out_if and the defines header
`include "binary_gcd_lcm_unit_core_defines.svh"

module binary_gcd_lcm_unit_core #(
    parameter int WIDTH = bgl_pkg::WIDTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bgl_in_if.sink    i_in,
    bgl_out_if.source o_out
);

    localparam int CW = $clog2(WIDTH + 1);

    bgl_pkg::t_state r_state, n_state;

    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH-1:0] r_x0, n_x0;
    logic [WIDTH-1:0] r_y0, n_y0;
    logic [WIDTH-1:0] r_g, n_g;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_hi, n_hi;
    logic [CW-1:0]    r_shared, n_shared;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_gcd_out, n_gcd_out;
    logic [WIDTH-1:0] r_lcm_out, n_lcm_out;
    logic             r_ovf_out, n_ovf_out;

    // shared add/subtract unit; for subtract the top bit is the borrow
    logic [WIDTH:0]   u_a;
    logic [WIDTH:0]   u_b;
    logic             u_sub;
    logic [WIDTH+1:0] u_sum;
    logic             u_borrow;

    assign u_sum = {1'b0, u_a} + ({1'b0, u_b} ^ {(WIDTH + 2){u_sub}})
                 + (WIDTH + 2)'(u_sub);
    assign u_borrow = u_sum[WIDTH+1];

    assign i_in.ready         = (r_state == bgl_pkg::ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.gcd_result   = r_gcd_out;
    assign o_out.lcm_result   = r_lcm_out;
    assign o_out.lcm_overflow = r_ovf_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bgl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_y       <= n_y;
        r_x0      <= n_x0;
        r_y0      <= n_y0;
        r_g       <= n_g;
        r_rem     <= n_rem;
        r_hi      <= n_hi;
        r_shared  <= n_shared;
        r_cnt     <= n_cnt;
        r_gcd_out <= n_gcd_out;
        r_lcm_out <= n_lcm_out;
        r_ovf_out <= n_ovf_out;
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_g         = r_g;
        n_rem       = r_rem;
        n_hi        = r_hi;
        n_shared    = r_shared;
        n_cnt       = r_cnt;
        n_gcd_out   = r_gcd_out;
        n_lcm_out   = r_lcm_out;
        n_ovf_out   = r_ovf_out;
        n_out_valid = r_out_valid;
        u_a         = '0;
        u_b         = '0;
        u_sub       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            bgl_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_x      = i_in.x_value;
                    n_y      = i_in.y_value;
                    n_x0     = i_in.x_value;
                    n_y0     = i_in.y_value;
                    n_shared = '0;
                    n_state  = bgl_pkg::ST_CHECK;
                end
            end
            bgl_pkg::ST_CHECK: begin
                if (r_x == '0 || r_y == '0) begin
                    // gcd is the other operand, lcm is zero
                    n_g     = r_x | r_y;
                    n_y     = '0;
                    n_hi    = '0;
                    n_state = bgl_pkg::ST_DONE;
                end else begin
                    n_state = bgl_pkg::ST_STRIP;
                end
            end
            bgl_pkg::ST_STRIP: begin
                if (r_x[0] || r_y[0]) begin
                    if (!r_x[0]) begin
                        n_x = r_y;
                        n_y = r_x;
                    end
                    n_state = bgl_pkg::ST_REDUCE;
                end else begin
                    n_x      = r_x >> 1;
                    n_y      = r_y >> 1;
                    n_shared = r_shared + 1'b1;
                end
            end
            bgl_pkg::ST_REDUCE: begin
                u_a   = {1'b0, r_y};
                u_b   = {1'b0, r_x};
                u_sub = 1'b1;
                priority if (r_y == '0) begin
                    n_state = bgl_pkg::ST_SCALE;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (u_borrow) begin
                    // y below x: swap so the next cycle subtracts the smaller
                    n_x = r_y;
                    n_y = r_x;
                end else begin
                    n_y = u_sum[WIDTH-1:0];
                end
            end
            bgl_pkg::ST_SCALE: begin
                n_g     = r_x << r_shared;
                n_y     = r_y0;
                n_rem   = '0;
                n_hi    = '0;
                n_cnt   = '0;
                n_state = bgl_pkg::ST_DIVIDE;
            end
            bgl_pkg::ST_DIVIDE: begin
                // restoring division, quotient bits shift into r_y
                u_a   = {r_rem, r_y[WIDTH-1]};
                u_b   = {1'b0, r_g};
                u_sub = 1'b1;
                if (u_borrow) begin
                    n_rem = u_a[WIDTH-1:0];
                end else begin
                    n_rem = u_sum[WIDTH-1:0];
                end
                n_y   = {r_y[WIDTH-2:0], ~u_borrow};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_cnt   = '0;
                    n_state = bgl_pkg::ST_MULT;
                end
            end
            bgl_pkg::ST_MULT: begin
                // shift-and-add, low product half replaces the quotient
                u_a   = {1'b0, r_hi};
                u_b   = r_y[0] ? {1'b0, r_x0} : '0;
                u_sub = 1'b0;
                n_hi  = u_sum[WIDTH:1];
                n_y   = {u_sum[0], r_y[WIDTH-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_state = bgl_pkg::ST_DONE;
                end
            end
            bgl_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_gcd_out   = r_g;
                    n_lcm_out   = r_y;
                    n_ovf_out   = |r_hi;
                    n_out_valid = 1'b1;
                    n_state     = bgl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bgl_pkg::ST_IDLE;
            end
        endcase
    end

    `BGL_ASSERT_NOW(a_reduce_x_odd, i_clk, i_rst_n,
        r_state == bgl_pkg::ST_REDUCE, r_x[0], "x even in reduce loop")
    `BGL_ASSERT_NOW(a_divisor_nonzero, i_clk, i_rst_n,
        r_state == bgl_pkg::ST_DIVIDE, r_g != '0, "division by zero gcd")
    `BGL_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        i_in.valid && i_in.ready, r_state == bgl_pkg::ST_CHECK, "accepted item not started")

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for binary_gcd_lcm_unit_core: random and corner operand pairs
// depends on bgl_pkg, bgl_in_if, bgl_out_if and the unit's rtl
`timescale 1ns / 100ps

module testbench;

    localparam int W = bgl_pkg::WIDTH_DEFAULT;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] gcd;
        logic [W-1:0] lcm;
        logic         ovf;
    } t_gcd_lcm;

    class gcd_lcm_scoreboard;
        t_gcd_lcm    expected_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned zero_operands;
        int unsigned overflows;

        function new();
            mismatches = 0;
            checked = 0;
            zero_operands = 0;
            overflows = 0;
        endfunction

        // stein's method: strip shared twos, then halve and subtract
        function logic [W-1:0] binary_gcd(logic [W-1:0] a, logic [W-1:0] b);
            int unsigned  twos;
            logic [W-1:0] t;
            twos = 0;
            if (a == 0) return b;
            if (b == 0) return a;
            while (a[0] == 1'b0 && b[0] == 1'b0) begin
                a = a >> 1;
                b = b >> 1;
                twos++;
            end
            if (a[0] == 1'b0) begin
                t = a;
                a = b;
                b = t;
            end
            while (b != 0) begin
                while (b[0] == 1'b0) b = b >> 1;
                if (a < b) begin
                    b = b - a;
                end else begin
                    t = a - b;
                    a = b;
                    b = t;
                end
            end
            return a << twos;
        endfunction

        function void note_operands(logic [W-1:0] x, logic [W-1:0] y);
            t_gcd_lcm       e;
            logic [W-1:0]   q;
            logic [2*W-1:0] prod;
            e.x = x;
            e.y = y;
            e.gcd = binary_gcd(x, y);
            e.lcm = '0;
            e.ovf = 1'b0;
            if (e.gcd != 0) begin
                q = y / e.gcd;
                prod = {{W{1'b0}}, x} * {{W{1'b0}}, q};
                e.lcm = prod[W-1:0];
                e.ovf = |prod[2*W-1:W];
            end
            if (x == 0 || y == 0) zero_operands++;
            if (e.ovf) overflows++;
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [W-1:0] g, logic [W-1:0] l, logic o);
            t_gcd_lcm e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no pending item: gcd %h lcm %h ovf %b",
                         $time, g, l, o);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (g !== e.gcd) begin
                $display("%0t: gcd mismatch x=%h y=%h expected %h actual %h",
                         $time, e.x, e.y, e.gcd, g);
                mismatches++;
            end
            if (l !== e.lcm) begin
                $display("%0t: lcm mismatch x=%h y=%h expected %h actual %h",
                         $time, e.x, e.y, e.lcm, l);
                mismatches++;
            end
            if (o !== e.ovf) begin
                $display("%0t: overflow mismatch x=%h y=%h expected %b actual %b",
                         $time, e.x, e.y, e.ovf, o);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic burst_mode;

    bgl_in_if  #(.WIDTH(W)) op_ch ();
    bgl_out_if #(.WIDTH(W)) res_ch ();

    binary_gcd_lcm_unit_core #(.WIDTH(W)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    gcd_lcm_scoreboard sb = new();

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_operands(logic [W-1:0] x, logic [W-1:0] y);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            op_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op_ch.valid = 1'b1;
        op_ch.x_value = x;
        op_ch.y_value = y;
        forever begin
            @(posedge clk);
            if (op_ch.ready) break;
        end
        sb.note_operands(x, y);
        @(negedge clk);
    endtask

    task automatic random_pair(output logic [W-1:0] x, output logic [W-1:0] y);
        logic [W-1:0] f;
        case ($urandom_range(0, 9))
            0, 1: begin
                x = $urandom;
                y = $urandom;
            end
            2, 3: begin
                // shared factor so the reduce loop ends on a nontrivial gcd
                f = $urandom_range(1, 65535) << $urandom_range(0, 8);
                x = f * $urandom_range(1, 4095);
                y = f * $urandom_range(1, 4095);
            end
            4: begin
                x = $urandom_range(0, 255);
                y = $urandom_range(0, 255);
            end
            5: begin
                x = $urandom << $urandom_range(0, 31);
                y = $urandom << $urandom_range(0, 31);
            end
            6: begin
                x = $urandom >> $urandom_range(0, 31);
                y = 0;
                if ($urandom_range(0, 1)) begin
                    y = x;
                    x = 0;
                end
            end
            7: begin
                x = $urandom >> $urandom_range(0, 31);
                y = x * $urandom_range(1, 5);
            end
            8: begin
                // around the overflow boundary of the lcm
                x = $urandom_range(32768, 131071);
                y = $urandom_range(32768, 131071);
            end
            default: begin
                x = $urandom >> $urandom_range(0, 31);
                y = $urandom >> $urandom_range(0, 31);
            end
        endcase
    endtask

    // result side: random stalls, sampled at the rising edge
    initial begin
        int unsigned gap;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            gap = burst_mode ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            forever begin
                @(posedge clk);
                if (res_ch.valid) break;
            end
            sb.check_result(res_ch.gcd_result, res_ch.lcm_result, res_ch.lcm_overflow);
            @(negedge clk);
        end
    end

    initial begin
        logic [W-1:0] x;
        logic [W-1:0] y;
        rst_n = 1'b0;
        burst_mode = 1'b0;
        op_ch.valid = 1'b0;
        op_ch.x_value = '0;
        op_ch.y_value = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corners: zero operands, extremes, powers of two, overflow edges
        send_operands(32'h0000_0000, 32'h0000_0000);
        send_operands(32'h0000_0000, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'h0000_0000);
        send_operands(32'h0000_0000, 32'h0000_0001);
        send_operands(32'h0000_0007, 32'h0000_0000);
        send_operands(32'h0000_0001, 32'h0000_0001);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'h0000_0001, 32'hFFFF_FFFF);
        send_operands(32'h0000_0002, 32'hFFFF_FFFF);
        send_operands(32'h8000_0000, 32'h8000_0000);
        send_operands(32'h8000_0000, 32'h4000_0000);
        send_operands(32'h8000_0000, 32'h0000_0001);
        send_operands(32'h8000_0000, 32'h0000_0003);
        send_operands(32'h0001_0000, 32'h0001_0001);
        send_operands(32'h0000_FFFF, 32'h0001_0001);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        send_operands(32'h0000_0012, 32'h0000_0018);
        send_operands(32'h0000_0011, 32'h0000_000D);
        send_operands(32'hC000_0000, 32'h3000_0000);
        send_operands(32'hFFFF_0000, 32'h0000_FFFF);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // every so often switch to a stretch with no idling on either side
            if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            random_pair(x, y);
            send_operands(x, y);
        end
        op_ch.valid = 1'b0;
        burst_mode = 1'b0;

        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results, %0d with a zero operand, %0d with lcm overflow",
                 sb.checked, sb.zero_operands, sb.overflows);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("timeout with %0d items still pending", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bgl_pkg.sv
hw/rtl/bgl_in_if.sv
hw/rtl/bgl_out_if.sv
hw/rtl/binary_gcd_lcm_unit_core.sv
sim/testbench.sv
